FILE: rtl/rrhc_pkg.sv
// Shared types and constants of the RPC-over-RDMA header checker.
package rrhc_pkg;

  // Longest message the length counter tracks before it saturates
  localparam int MAX_MESSAGE_BYTES = 65536;
  localparam int BYTE_CAP_INT = (MAX_MESSAGE_BYTES < 131071) ? MAX_MESSAGE_BYTES : 131071;
  localparam logic [16:0] BYTE_CAP = 17'(BYTE_CAP_INT);

  // Minimum lengths per message type
  localparam logic [16:0] HDR_BYTES      = 17'd16;
  localparam logic [16:0] MSG_MIN_BYTES  = HDR_BYTES + 17'd12;
  localparam logic [16:0] MSGP_MIN_BYTES = MSG_MIN_BYTES + 17'd8;

  // Words per list element
  localparam logic [33:0] READ_ENTRY_WORDS = 34'd5;

  // Count saturation points
  localparam logic [11:0] READ_SAT  = 12'd4095;
  localparam logic [13:0] WRITE_SAT = 14'd8192;

  // Message type codes
  localparam logic [2:0] TYPE_MSG     = 3'd0;
  localparam logic [2:0] TYPE_NOMSG   = 3'd1;
  localparam logic [2:0] TYPE_MSGP    = 3'd2;
  localparam logic [2:0] TYPE_DONE    = 3'd3;
  localparam logic [2:0] TYPE_ERROR   = 3'd4;
  localparam logic [2:0] TYPE_UNKNOWN = 3'd7;

  // Failure causes
  localparam logic [2:0] CAUSE_NONE     = 3'd0;
  localparam logic [2:0] CAUSE_SHORT    = 3'd1;
  localparam logic [2:0] CAUSE_TYPE     = 3'd2;
  localparam logic [2:0] CAUSE_TRUNC    = 3'd3;
  localparam logic [2:0] CAUSE_NO_XID   = 3'd4;
  localparam logic [2:0] CAUSE_XID_MISS = 3'd5;

  // One message word as taken from the receive side
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } item_t;

  // Verdict for one message
  typedef struct packed {
    logic        accepted;
    logic [2:0]  fail_cause;
    logic [2:0]  message_type;
    logic [31:0] message_xid;
    logic [11:0] read_chunks;
    logic [13:0] write_chunks;
    logic        reply_present;
    logic [16:0] header_bytes;
  } verdict_t;

endpackage

FILE: rtl/rrhc_if.sv
// Stream channels of the header checker: message words in, verdicts out.
interface rrhc_msg_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source(output valid, word, valid_bytes, last_word, input ready);
  modport sink(input valid, word, valid_bytes, last_word, output ready);
endinterface

interface rrhc_verdict_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  fail_cause;
  logic [2:0]  message_type;
  logic [31:0] message_xid;
  logic [11:0] read_chunks;
  logic [13:0] write_chunks;
  logic        reply_present;
  logic [16:0] header_bytes;

  modport source(output valid, accepted, fail_cause, message_type, message_xid,
                 read_chunks, write_chunks, reply_present, header_bytes,
                 input ready);
  modport sink(input valid, accepted, fail_cause, message_type, message_xid,
               read_chunks, write_chunks, reply_present, header_bytes,
               output ready);
endinterface

FILE: rtl/rpc_rdma_header_checker_core.sv
// Top level of the RPC-over-RDMA v1 header checker.
// A message's last word is first held in the input register; its verdict then loads the
// verdict register, from which it is offered.
// Throughput: one word per cycle; the input stalls only while a finished verdict waits
// and the registered word is a last word.
// Reset (rst, synchronous) empties both registers and returns the parser to the header.
module rpc_rdma_header_checker_core (
  input  logic           clk,
  input  logic           rst,
  rrhc_msg_if.sink       msg,
  rrhc_verdict_if.source verdict
);

  logic               s1_valid;
  rrhc_pkg::item_t    s1_item;
  logic               s1_take;
  logic               out_free;
  logic               out_valid;
  rrhc_pkg::verdict_t parse_result;
  rrhc_pkg::verdict_t out_result;

  // Advance the registered word unless its verdict has nowhere to go
  assign out_free  = !out_valid || verdict.ready;
  assign s1_take   = s1_valid && (!s1_item.last_word || out_free);
  assign msg.ready = !s1_valid || s1_take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg.ready) begin
      s1_valid <= msg.valid;
    end
    if (msg.valid && msg.ready) begin
      s1_item <= '{word: msg.word, valid_bytes: msg.valid_bytes, last_word: msg.last_word};
    end
  end

  rrhc_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .take   (s1_take),
    .item   (s1_item),
    .result (parse_result)
  );

  // Verdict register: load on a last word, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take && s1_item.last_word) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_take && s1_item.last_word) begin
      out_result <= parse_result;
    end
  end

  assign verdict.valid         = out_valid;
  assign verdict.accepted      = out_result.accepted;
  assign verdict.fail_cause    = out_result.fail_cause;
  assign verdict.message_type  = out_result.message_type;
  assign verdict.message_xid   = out_result.message_xid;
  assign verdict.read_chunks   = out_result.read_chunks;
  assign verdict.write_chunks  = out_result.write_chunks;
  assign verdict.reply_present = out_result.reply_present;
  assign verdict.header_bytes  = out_result.header_bytes;

endmodule

FILE: rtl/rrhc_parser.sv
// Parse state machine: walks header and chunk lists one word per cycle while take is high.
module rrhc_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  rrhc_pkg::item_t   item,
  output rrhc_pkg::verdict_t result
);

  typedef enum logic [3:0] {
    PH_HDR,
    PH_READ_FLAG,
    PH_READ_ENTRY,
    PH_WRITE_FLAG,
    PH_WRITE_COUNT,
    PH_WRITE_SEGS,
    PH_REPLY_FLAG,
    PH_REPLY_COUNT,
    PH_REPLY_SEGS,
    PH_RPC_XID,
    PH_PASS
  } phase_t;

  phase_t      parse_phase, parse_phase_next;
  logic [2:0]  header_word_index, header_word_index_next;
  logic [33:0] words_left_in_entry, words_left_in_entry_next;
  logic [31:0] saved_xid, saved_xid_next;
  logic [2:0]  saved_type, saved_type_next;
  logic [11:0] read_count, read_count_next;
  logic [13:0] write_count, write_count_next;
  logic        reply_flag, reply_flag_next;
  logic [16:0] byte_position, byte_position_next;
  logic        verdict_done, verdict_done_next;
  logic [2:0]  verdict_cause, verdict_cause_next;

  logic [2:0]  add;
  logic        full;
  logic [16:0] byte_sum;
  logic [33:0] left_dec;
  logic [33:0] seg_words;
  logic        type_known;
  logic [2:0]  cause;

  // Bytes this word adds to the message length
  always_comb begin
    if (!item.last_word) begin
      add = 3'd4;
    end else if (item.valid_bytes > 3'd4) begin
      add = 3'd4;
    end else begin
      add = item.valid_bytes;
    end
    full      = (add == 3'd4);
    byte_sum  = byte_position + 17'(add);
    left_dec  = (words_left_in_entry != 34'd0) ? words_left_in_entry - 34'd1 : 34'd0;
    seg_words = {item.word, 2'b00};
  end

  // Advance the parse state by one word
  always_comb begin
    parse_phase_next         = parse_phase;
    header_word_index_next   = header_word_index;
    words_left_in_entry_next = words_left_in_entry;
    saved_xid_next           = saved_xid;
    saved_type_next          = saved_type;
    read_count_next          = read_count;
    write_count_next         = write_count;
    reply_flag_next          = reply_flag;
    byte_position_next       = byte_position;
    verdict_done_next        = verdict_done;
    verdict_cause_next       = verdict_cause;

    // Count length until the lists are done
    if (parse_phase != PH_RPC_XID && parse_phase != PH_PASS) begin
      byte_position_next = (byte_sum > rrhc_pkg::BYTE_CAP) ? rrhc_pkg::BYTE_CAP : byte_sum;
    end

    if (full && !verdict_done) begin
      case (parse_phase)
        PH_HDR: begin
          if (header_word_index == 3'd0) begin
            saved_xid_next = item.word;
          end
          if (header_word_index == 3'd3) begin
            if (item.word == 32'(rrhc_pkg::TYPE_MSG) ||
                item.word == 32'(rrhc_pkg::TYPE_MSGP)) begin
              saved_type_next = item.word[2:0];
              if (item.word == 32'(rrhc_pkg::TYPE_MSG)) begin
                parse_phase_next = PH_READ_FLAG;
              end
            end else if (item.word == 32'(rrhc_pkg::TYPE_NOMSG) ||
                         item.word == 32'(rrhc_pkg::TYPE_DONE) ||
                         item.word == 32'(rrhc_pkg::TYPE_ERROR)) begin
              saved_type_next  = item.word[2:0];
              parse_phase_next = PH_PASS;
            end else begin
              saved_type_next    = rrhc_pkg::TYPE_UNKNOWN;
              verdict_done_next  = 1'b1;
              verdict_cause_next = rrhc_pkg::CAUSE_TYPE;
            end
          end
          if (header_word_index == 3'd5) begin
            parse_phase_next = PH_READ_FLAG;
          end
          header_word_index_next = header_word_index + 3'd1;
        end
        PH_READ_FLAG: begin
          if (item.word != 32'd0) begin
            if (read_count < rrhc_pkg::READ_SAT) begin
              read_count_next = read_count + 12'd1;
            end
            words_left_in_entry_next = rrhc_pkg::READ_ENTRY_WORDS;
            parse_phase_next         = PH_READ_ENTRY;
          end else begin
            parse_phase_next = PH_WRITE_FLAG;
          end
        end
        PH_READ_ENTRY: begin
          words_left_in_entry_next = left_dec;
          if (left_dec == 34'd0) begin
            parse_phase_next = PH_READ_FLAG;
          end
        end
        PH_WRITE_FLAG: begin
          if (item.word != 32'd0) begin
            if (write_count < rrhc_pkg::WRITE_SAT) begin
              write_count_next = write_count + 14'd1;
            end
            parse_phase_next = PH_WRITE_COUNT;
          end else begin
            parse_phase_next = PH_REPLY_FLAG;
          end
        end
        PH_WRITE_COUNT: begin
          words_left_in_entry_next = seg_words;
          parse_phase_next = (seg_words == 34'd0) ? PH_WRITE_FLAG : PH_WRITE_SEGS;
        end
        PH_WRITE_SEGS: begin
          words_left_in_entry_next = left_dec;
          if (left_dec == 34'd0) begin
            parse_phase_next = PH_WRITE_FLAG;
          end
        end
        PH_REPLY_FLAG: begin
          if (item.word != 32'd0) begin
            reply_flag_next  = 1'b1;
            parse_phase_next = PH_REPLY_COUNT;
          end else begin
            parse_phase_next = PH_RPC_XID;
          end
        end
        PH_REPLY_COUNT: begin
          words_left_in_entry_next = seg_words;
          parse_phase_next = (seg_words == 34'd0) ? PH_RPC_XID : PH_REPLY_SEGS;
        end
        PH_REPLY_SEGS: begin
          words_left_in_entry_next = left_dec;
          if (left_dec == 34'd0) begin
            parse_phase_next = PH_RPC_XID;
          end
        end
        PH_RPC_XID: begin
          if (item.word == saved_xid) begin
            parse_phase_next = PH_PASS;
          end else begin
            verdict_done_next  = 1'b1;
            verdict_cause_next = rrhc_pkg::CAUSE_XID_MISS;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Judge the message from the state after this word
  always_comb begin
    type_known = (parse_phase_next != PH_HDR) || (header_word_index_next >= 3'd4) ||
                 verdict_done_next;
    if (verdict_done_next) begin
      cause = verdict_cause_next;
    end else if (byte_position_next < rrhc_pkg::HDR_BYTES || !type_known) begin
      cause = rrhc_pkg::CAUSE_SHORT;
    end else if (saved_type_next == rrhc_pkg::TYPE_MSG &&
                 byte_position_next < rrhc_pkg::MSG_MIN_BYTES) begin
      cause = rrhc_pkg::CAUSE_SHORT;
    end else if (saved_type_next == rrhc_pkg::TYPE_MSGP &&
                 byte_position_next < rrhc_pkg::MSGP_MIN_BYTES) begin
      cause = rrhc_pkg::CAUSE_SHORT;
    end else if (parse_phase_next == PH_PASS) begin
      cause = rrhc_pkg::CAUSE_NONE;
    end else if (parse_phase_next == PH_RPC_XID) begin
      cause = rrhc_pkg::CAUSE_NO_XID;
    end else begin
      cause = rrhc_pkg::CAUSE_TRUNC;
    end

    result.accepted      = (cause == rrhc_pkg::CAUSE_NONE);
    result.fail_cause    = cause;
    result.message_type  = type_known ? saved_type_next : rrhc_pkg::TYPE_UNKNOWN;
    result.message_xid   = saved_xid_next;
    result.read_chunks   = read_count_next;
    result.write_chunks  = write_count_next;
    result.reply_present = reply_flag_next;
    result.header_bytes  = (cause == rrhc_pkg::CAUSE_NONE) ? byte_position_next : 17'd0;
  end

  // Hold parse state; clear it after each last word
  always_ff @(posedge clk) begin
    if (rst || (take && item.last_word)) begin
      parse_phase         <= PH_HDR;
      header_word_index   <= 3'd0;
      words_left_in_entry <= 34'd0;
      saved_xid           <= 32'd0;
      saved_type          <= 3'd0;
      read_count          <= 12'd0;
      write_count         <= 14'd0;
      reply_flag          <= 1'b0;
      byte_position       <= 17'd0;
      verdict_done        <= 1'b0;
      verdict_cause       <= 3'd0;
    end else if (take) begin
      parse_phase         <= parse_phase_next;
      header_word_index   <= header_word_index_next;
      words_left_in_entry <= words_left_in_entry_next;
      saved_xid           <= saved_xid_next;
      saved_type          <= saved_type_next;
      read_count          <= read_count_next;
      write_count         <= write_count_next;
      reply_flag          <= reply_flag_next;
      byte_position       <= byte_position_next;
      verdict_done        <= verdict_done_next;
      verdict_cause       <= verdict_cause_next;
    end
  end

  // An early failure is only ever a bad type or an xid mismatch
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    verdict_done |-> (verdict_cause == rrhc_pkg::CAUSE_TYPE ||
                      verdict_cause == rrhc_pkg::CAUSE_XID_MISS))
    else $error("early verdict with unexpected cause");

  // A counted phase always has words left to consume
  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_READ_ENTRY || parse_phase == PH_WRITE_SEGS ||
     parse_phase == PH_REPLY_SEGS) |-> (words_left_in_entry != 34'd0))
    else $error("counted phase with no words left");

  // The last word of a message leaves the parser clean
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (take && item.last_word) |=> (parse_phase == PH_HDR && byte_position == 17'd0 &&
                                  !verdict_done))
    else $error("state not cleared after last word");

  // The length counter never passes its cap
  a_byte_cap: assert property (@(posedge clk) disable iff (rst)
    byte_position <= rrhc_pkg::BYTE_CAP)
    else $error("byte position beyond cap");

endmodule
